/* rtl/core/apcid_pkg.sv */
`default_nettype none
package apcid_pkg;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [0:0] KIND_HEADER  = 1'b0;
   localparam logic [0:0] KIND_PAYLOAD = 1'b1;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_LENGTH  = 2'd1;
   localparam logic [1:0] STATUS_INVALID = 2'd2;

   localparam logic [1:0] FORMAT_I = 2'd0;
   localparam logic [1:0] FORMAT_S = 2'd1;
   localparam logic [1:0] FORMAT_U = 2'd2;

   localparam logic [1:0] SVC_NONE  = 2'd0;
   localparam logic [1:0] SVC_START = 2'd1;
   localparam logic [1:0] SVC_STOP  = 2'd2;
   localparam logic [1:0] SVC_TEST  = 2'd3;

   localparam logic [7:0] CTRL_S_FRAME = 8'h01;
   localparam logic [7:0] ACT_STARTDT  = 8'h07;
   localparam logic [7:0] ACT_STOPDT   = 8'h13;
   localparam logic [7:0] ACT_TESTFR   = 8'h43;
   localparam logic [7:0] CON_STARTDT  = 8'h0B;
   localparam logic [7:0] CON_STOPDT   = 8'h23;
   localparam logic [7:0] CON_TESTFR   = 8'h83;

   localparam logic [7:0] HEADER_TOTAL = 8'd6;
   localparam logic [7:0] LEN_MIN      = 8'd4;
   localparam logic [7:0] LEN_MAX      = 8'd253;

   // classified event from the front end
   typedef struct packed {
      logic [0:0]      kind;
      logic [1:0]      status;
      logic [3:0][7:0] octets;
      logic [7:0]      payload_length;
      logic [7:0]      payload_byte;
      logic            payload_last;
   } event_type;

endpackage
`default_nettype wire

/* rtl/core/apcid_front.sv */
`default_nettype none
module apcid_front
   import apcid_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      accept,
   input  wire logic [7:0] data_byte,
   output logic           ev_valid,
   output event_type      ev
);

   typedef enum logic [3:0] {
      PH_START = 4'b0001,
      PH_LEN   = 4'b0010,
      PH_CTRL  = 4'b0100,
      PH_BODY  = 4'b1000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] byte_index_ff, byte_index_in;
   logic [7:0] frame_total_ff, frame_total_in;
   logic       skip_ff, skip_in;
   logic [7:0] oct0_ff, oct1_ff, oct2_ff;
   logic [1:0] slot;
   logic       is_i;
   logic       valid_frame;
   logic       last;

   assign slot        = byte_index_ff[1:0] - 2'd2;
   assign is_i        = ~oct0_ff[0];
   assign valid_frame = is_i ? (frame_total_ff > HEADER_TOTAL)
                             : (frame_total_ff == HEADER_TOTAL);
   assign last        = byte_index_ff >= (frame_total_ff - 8'd1);

   always_comb begin
      phase_in       = phase_ff;
      byte_index_in  = byte_index_ff;
      frame_total_in = frame_total_ff;
      skip_in        = skip_ff;
      ev_valid       = 1'b0;
      ev             = '0;
      case (phase_ff)
         PH_START: begin
            byte_index_in = 8'd1;
            phase_in      = PH_LEN;
         end
         PH_LEN: begin
            if (data_byte inside {[LEN_MIN:LEN_MAX]}) begin
               frame_total_in = data_byte + 8'd2;
               byte_index_in  = 8'd2;
               phase_in       = PH_CTRL;
            end else begin
               ev_valid       = 1'b1;
               ev.kind        = KIND_HEADER;
               ev.status      = STATUS_LENGTH;
               byte_index_in  = 8'd0;
               frame_total_in = 8'd0;
               phase_in       = PH_START;
            end
         end
         PH_CTRL: begin
            byte_index_in = byte_index_ff + 8'd1;
            if (byte_index_ff >= 8'd5) begin
               ev_valid          = 1'b1;
               ev.kind           = KIND_HEADER;
               ev.status         = valid_frame ? STATUS_OK : STATUS_INVALID;
               ev.octets         = {data_byte, oct2_ff, oct1_ff, oct0_ff};
               ev.payload_length = frame_total_ff - HEADER_TOTAL;
               if (frame_total_ff == HEADER_TOTAL) begin
                  phase_in = PH_START;
                  skip_in  = 1'b0;
               end else begin
                  phase_in = PH_BODY;
                  skip_in  = ~valid_frame;
               end
            end
         end
         PH_BODY: begin
            byte_index_in = byte_index_ff + 8'd1;
            if (last) begin
               phase_in = PH_START;
            end
            if (skip_ff) begin
               if (last) begin
                  skip_in = 1'b0;
               end
            end else begin
               ev_valid        = 1'b1;
               ev.kind         = KIND_PAYLOAD;
               ev.payload_byte = data_byte;
               ev.payload_last = last;
            end
         end
         default: begin
            phase_in = PH_START;
            skip_in  = 1'b0;
         end
      endcase
      if (!accept) begin
         ev_valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_START;
         byte_index_ff  <= 8'd0;
         frame_total_ff <= 8'd0;
         skip_ff        <= 1'b0;
      end else if (accept) begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         frame_total_ff <= frame_total_in;
         skip_ff        <= skip_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && (phase_ff == PH_CTRL)) begin
         case (slot)
            2'd0:    oct0_ff <= data_byte;
            2'd1:    oct1_ff <= data_byte;
            2'd2:    oct2_ff <= data_byte;
            default: ;
         endcase
      end
   end

endmodule
`default_nettype wire

/* rtl/core/apcid_queue.sv */
`default_nettype none
module apcid_queue
   import apcid_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      wr_en,
   input  wire event_type wr_data,
   output logic           full,
   input  wire logic      rd_en,
   output logic           rd_valid,
   output event_type      rd_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   event_type          slots_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_wr;
   logic               do_rd;

   assign full     = count_ff == CNT_W'(DEPTH);
   assign rd_valid = count_ff != '0;
   assign rd_data  = slots_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         slots_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule
`default_nettype wire

/* rtl/core/apcid_back.sv */
`default_nettype none
module apcid_back
   import apcid_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        q_valid,
   input  wire event_type   q_data,
   output logic             q_pop,
   output logic             empty,
   input  wire logic        pop,
   output logic [0:0]       rsp_result_kind,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_frame_format,
   output logic [1:0]       rsp_service_act,
   output logic [1:0]       rsp_service_con,
   output logic [14:0]      rsp_send_seq,
   output logic [14:0]      rsp_recv_seq,
   output logic [7:0]       rsp_payload_length,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_payload_last
);

   logic        out_valid_ff, out_valid_in;
   logic [0:0]  kind_ff, kind_in;
   logic [1:0]  status_ff, status_in;
   logic [1:0]  format_ff, format_in;
   logic [1:0]  act_ff, act_in;
   logic [1:0]  con_ff, con_in;
   logic [14:0] send_ff, send_in;
   logic [14:0] recv_ff, recv_in;
   logic [7:0]  plen_ff, plen_in;
   logic [7:0]  pbyte_ff, pbyte_in;
   logic        plast_ff, plast_in;
   logic [7:0]  c;
   logic        is_i;
   logic        is_s;
   logic        decode;

   assign c      = q_data.octets[0];
   assign is_i   = ~c[0];
   assign is_s   = c == CTRL_S_FRAME;
   assign decode = (q_data.kind == KIND_HEADER) && (q_data.status != STATUS_LENGTH);
   assign q_pop  = q_valid && (!out_valid_ff || pop);

   always_comb begin
      kind_in   = q_data.kind;
      status_in = q_data.status;
      format_in = FORMAT_I;
      act_in    = SVC_NONE;
      con_in    = SVC_NONE;
      send_in   = '0;
      recv_in   = '0;
      plen_in   = '0;
      pbyte_in  = q_data.payload_byte;
      plast_in  = q_data.payload_last;
      if (decode) begin
         format_in = is_i ? FORMAT_I : (is_s ? FORMAT_S : FORMAT_U);
         case (c)
            ACT_STARTDT: act_in = SVC_START;
            ACT_STOPDT:  act_in = SVC_STOP;
            ACT_TESTFR:  act_in = SVC_TEST;
            default:     act_in = SVC_NONE;
         endcase
         case (c)
            CON_STARTDT: con_in = SVC_START;
            CON_STOPDT:  con_in = SVC_STOP;
            CON_TESTFR:  con_in = SVC_TEST;
            default:     con_in = SVC_NONE;
         endcase
         if (is_i) begin
            send_in = {q_data.octets[1], c[7:1]};
         end
         if (is_i || is_s) begin
            recv_in = {q_data.octets[3], q_data.octets[2][7:1]};
         end
         plen_in = q_data.payload_length;
      end
      out_valid_in = out_valid_ff;
      if (q_pop) begin
         out_valid_in = 1'b1;
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         kind_ff   <= kind_in;
         status_ff <= status_in;
         format_ff <= format_in;
         act_ff    <= act_in;
         con_ff    <= con_in;
         send_ff   <= send_in;
         recv_ff   <= recv_in;
         plen_ff   <= plen_in;
         pbyte_ff  <= pbyte_in;
         plast_ff  <= plast_in;
      end
   end

   assign empty              = ~out_valid_ff;
   assign rsp_result_kind    = kind_ff;
   assign rsp_status         = status_ff;
   assign rsp_frame_format   = format_ff;
   assign rsp_service_act    = act_ff;
   assign rsp_service_con    = con_ff;
   assign rsp_send_seq       = send_ff;
   assign rsp_recv_seq       = recv_ff;
   assign rsp_payload_length = plen_ff;
   assign rsp_payload_byte   = pbyte_ff;
   assign rsp_payload_last   = plast_ff;

endmodule
`default_nettype wire

/* rtl/core/apcid_frame_deframer.sv */
// apci_frame_deframer: receive-side APCI frame splitter.
// Request channel: one link byte per request on req_data_byte, taken on an
// edge with push high and full low; a byte can be pushed every such cycle.
// Result channel: while empty is low, the oldest result sits on the rsp_
// ports; it is taken on an edge where pop is high. A result is either a
// header summary (kind 0, at the sixth byte of a frame or on a bad length
// byte) or a payload byte of a valid I frame (kind 1, last marked).
// A byte that yields a result writes it into the event queue at its push
// edge; the output register takes it when free. Throughput: one byte per
// cycle while full is low; the parser, the event queue and the output register
// each move one entry per cycle. Stalls: results wait in a QUEUE_DEPTH-entry
// queue plus the output register; full rises once the queue holds QUEUE_DEPTH
// results and the output register is occupied, and falls as soon as pop
// drains one. Reset (synchronous, active high) empties the queue and output
// register and puts the parser back to expecting a start byte.
`default_nettype none
module apci_frame_deframer
   import apcid_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic [7:0]  req_data_byte,
   output logic             empty,
   input  wire logic        pop,
   output logic [0:0]       rsp_result_kind,
   output logic [1:0]       rsp_status,
   output logic [1:0]       rsp_frame_format,
   output logic [1:0]       rsp_service_act,
   output logic [1:0]       rsp_service_con,
   output logic [14:0]      rsp_send_seq,
   output logic [14:0]      rsp_recv_seq,
   output logic [7:0]       rsp_payload_length,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_payload_last
);

   logic      accept;
   logic      ev_valid;
   event_type ev;
   logic      q_full;
   logic      q_valid;
   logic      q_pop;
   event_type q_data;

   assign full   = q_full;
   assign accept = push && !q_full;

   apcid_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .data_byte (req_data_byte),
      .ev_valid  (ev_valid),
      .ev        (ev)
   );

   apcid_queue #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (ev_valid),
      .wr_data  (ev),
      .full     (q_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   apcid_back u_back (
      .clock              (clock),
      .reset              (reset),
      .q_valid            (q_valid),
      .q_data             (q_data),
      .q_pop              (q_pop),
      .empty              (empty),
      .pop                (pop),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_status         (rsp_status),
      .rsp_frame_format   (rsp_frame_format),
      .rsp_service_act    (rsp_service_act),
      .rsp_service_con    (rsp_service_con),
      .rsp_send_seq       (rsp_send_seq),
      .rsp_recv_seq       (rsp_recv_seq),
      .rsp_payload_length (rsp_payload_length),
      .rsp_payload_byte   (rsp_payload_byte),
      .rsp_payload_last   (rsp_payload_last)
   );

endmodule
`default_nettype wire
